// File: rtl/core/sdsf_pkg.sv
`default_nettype none

package sdsf_pkg;

  localparam int DIGITS  = 6;
  localparam int VALUE_W = 21;
  localparam int POS_W   = 3;
  localparam int SEG_W   = 8;
  localparam int MAG_W   = $clog2(10 ** DIGITS);
  localparam int BCD_W   = 4 * DIGITS;
  localparam int CNT_W   = $clog2(MAG_W);

  localparam logic signed [VALUE_W-1:0] VAL_MAX = VALUE_W'(10 ** DIGITS - 1);
  localparam logic signed [VALUE_W-1:0] VAL_MIN = VALUE_W'(-(10 ** (DIGITS - 1) - 1));

  localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;
  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

  // program steps
  localparam int PC_W = 2;
  localparam logic [PC_W-1:0] STEP_WAIT   = 2'd0;
  localparam logic [PC_W-1:0] STEP_DABBLE = 2'd1;
  localparam logic [PC_W-1:0] STEP_FORMAT = 2'd2;

  typedef enum logic [1:0] {
    OP_WAIT,
    OP_DABBLE,
    OP_FORMAT
  } op_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NOT_START,
    COND_CNT_NZ,
    COND_ALWAYS
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  // microprogram: jump to target when the condition holds, else fall through
  function automatic ctrl_t ctrl_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      STEP_WAIT:   w = '{op: OP_WAIT,   cond: COND_NOT_START, target: STEP_WAIT};
      STEP_DABBLE: w = '{op: OP_DABBLE, cond: COND_CNT_NZ,    target: STEP_DABBLE};
      STEP_FORMAT: w = '{op: OP_FORMAT, cond: COND_ALWAYS,    target: STEP_WAIT};
      default:     w = '{op: OP_WAIT,   cond: COND_ALWAYS,    target: STEP_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [SEG_W-1:0] seg_decode(input logic [3:0] nib);
    logic [SEG_W-1:0] s;
    case (nib)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/signed_decimal_seven_segment_formatter.sv
`default_nettype none

// Signed decimal formatter for a six-digit seven-segment row.
// Input: drive value and point_position and raise start; the item is taken
// at a rising edge with start high and busy low. busy stays high while the
// item is being converted, and start is ignored during that time.
// Output: one result per item. done is high for exactly one cycle, and
// segments_digit_0..5 (leftmost first, gfedcba with bit 7 as point) and
// overflow are valid in that cycle; they hold until the next result.
// The receiver cannot stall; a result must be taken in its done cycle.
// Conversion: the accepting edge loads the operands in the wait step; the
// dabble step shifts in the 20-bit magnitude bit by bit with add-3
// correction, then a format step registers the patterns and done. A new
// item may be accepted in the done cycle but not while busy, so the
// binary-to-decimal loop sets the throughput. Control is a three-step
// microprogram with a step counter. Reset (rst, synchronous) returns the
// sequencer to waiting and clears done; no item in flight survives it.
module signed_decimal_seven_segment_formatter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  output logic                                 done,
  input  logic signed [sdsf_pkg::VALUE_W-1:0]  value,
  input  logic [sdsf_pkg::POS_W-1:0]           point_position,
  output logic [sdsf_pkg::SEG_W-1:0]           segments_digit_0,
  output logic [sdsf_pkg::SEG_W-1:0]           segments_digit_1,
  output logic [sdsf_pkg::SEG_W-1:0]           segments_digit_2,
  output logic [sdsf_pkg::SEG_W-1:0]           segments_digit_3,
  output logic [sdsf_pkg::SEG_W-1:0]           segments_digit_4,
  output logic [sdsf_pkg::SEG_W-1:0]           segments_digit_5,
  output logic                                 overflow
);
  import sdsf_pkg::*;

  logic [PC_W-1:0]  pc;
  logic [PC_W-1:0]  pc_next;
  ctrl_t            ctrl;
  logic             take;
  logic [CNT_W-1:0] cnt;

  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] bcd_adj;
  logic [MAG_W-1:0] bin;
  logic             neg;
  logic             ovf;
  logic [POS_W-1:0] pos;

  logic signed [VALUE_W-1:0] clamped;
  logic                      clamp_ovf;
  logic [MAG_W-1:0]          mag;

  logic [SEG_W-1:0] seg_q    [DIGITS];
  logic [SEG_W-1:0] seg_next [DIGITS];
  logic             overflow_q;

  // sequencer
  always_comb begin
    ctrl = ctrl_rom(pc);
    case (ctrl.cond)
      COND_NOT_START: take = !start;
      COND_CNT_NZ:    take = (cnt != '0);
      COND_ALWAYS:    take = 1'b1;
      default:        take = 1'b0;
    endcase
    pc_next = take ? ctrl.target : pc + PC_W'(1);
  end

  assign busy = (pc != STEP_WAIT);

  // clamp and magnitude of the incoming value
  always_comb begin
    clamp_ovf = 1'b0;
    clamped   = value;
    if (value > VAL_MAX) begin
      clamped   = VAL_MAX;
      clamp_ovf = 1'b1;
    end else if (value < VAL_MIN) begin
      clamped   = VAL_MIN;
      clamp_ovf = 1'b1;
    end
    if (clamped[VALUE_W-1]) begin
      mag = MAG_W'(-clamped);
    end else begin
      mag = MAG_W'(clamped);
    end
  end

  // add 3 to every decimal digit of 5 or more before the shift
  always_comb begin
    bcd_adj = bcd;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
  end

  // patterns, leftmost digit first
  always_comb begin
    logic       seen;
    logic [3:0] nib;
    logic [SEG_W-1:0] pat;
    seen = 1'b0;
    for (int d = 0; d < DIGITS; d++) begin
      nib = bcd[4*(DIGITS-1-d) +: 4];
      if (nib != 4'd0) begin
        seen = 1'b1;
      end
      pat = (seen || d == DIGITS - 1) ? seg_decode(nib) : SEG_BLANK;
      if (pos != '0 && int'(pos) < DIGITS && int'(pos) == DIGITS - 1 - d) begin
        pat = pat | SEG_POINT;
      end
      seg_next[d] = pat;
    end
    if (neg) begin
      seg_next[0] = SEG_MINUS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= STEP_WAIT;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      pc   <= pc_next;
      done <= (ctrl.op == OP_FORMAT);
      case (ctrl.op)
        OP_WAIT: begin
          if (start) begin
            cnt <= CNT_W'(MAG_W - 1);
          end
        end
        OP_DABBLE: begin
          cnt <= cnt - CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_WAIT: begin
        if (start) begin
          bcd <= '0;
          bin <= mag;
          neg <= clamped[VALUE_W-1];
          ovf <= clamp_ovf;
          pos <= point_position;
        end
      end
      OP_DABBLE: begin
        bcd <= {bcd_adj[BCD_W-2:0], bin[MAG_W-1]};
        bin <= {bin[MAG_W-2:0], 1'b0};
      end
      OP_FORMAT: begin
        seg_q      <= seg_next;
        overflow_q <= ovf;
      end
      default: begin
      end
    endcase
  end

  assign segments_digit_0 = seg_q[0];
  assign segments_digit_1 = seg_q[1];
  assign segments_digit_2 = seg_q[2];
  assign segments_digit_3 = seg_q[3];
  assign segments_digit_4 = seg_q[4];
  assign segments_digit_5 = seg_q[5];
  assign overflow         = overflow_q;

  a_done_after_format: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(pc == STEP_FORMAT))
    else $error("done without a format step");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && pc == STEP_DABBLE))
    else $error("accepted item did not start conversion");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_minus_shape: assert property (@(posedge clk) disable iff (rst)
    (done && neg) |-> (segments_digit_0 == SEG_MINUS))
    else $error("negative result without minus on leftmost digit");

endmodule

`default_nettype wire

// File: sim/segment_pattern_checker.sv
`default_nettype none

module segment_pattern_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic                                 done,
  input  logic signed [sdsf_pkg::VALUE_W-1:0]  value,
  input  logic [sdsf_pkg::POS_W-1:0]           point_position,
  input  logic [sdsf_pkg::SEG_W-1:0]           segments_digit_0,
  input  logic [sdsf_pkg::SEG_W-1:0]           segments_digit_1,
  input  logic [sdsf_pkg::SEG_W-1:0]           segments_digit_2,
  input  logic [sdsf_pkg::SEG_W-1:0]           segments_digit_3,
  input  logic [sdsf_pkg::SEG_W-1:0]           segments_digit_4,
  input  logic [sdsf_pkg::SEG_W-1:0]           segments_digit_5,
  input  logic                                 overflow,
  output int                                   errors,
  output int                                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NDIG = sdsf_pkg::DIGITS;

  typedef struct packed {
    logic [NDIG-1:0][sdsf_pkg::SEG_W-1:0] seg;
    logic                                 ovf;
  } display_t;

  localparam logic [7:0] GLYPH [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  display_t pending_displays[$];

  function automatic display_t format_display(
    input logic signed [sdsf_pkg::VALUE_W-1:0] num,
    input logic [sdsf_pkg::POS_W-1:0]          pos
  );
    display_t  r;
    int        v;
    int        upper;
    int        lower;
    int        mag;
    int        digit [NDIG];
    bit        lit;
    bit        neg;
    logic [7:0] pat;
    v = int'(num);
    upper = 10 ** NDIG - 1;
    lower = -(10 ** (NDIG - 1) - 1);
    r.ovf = 1'b0;
    if (v > upper) begin
      v = upper;
      r.ovf = 1'b1;
    end else if (v < lower) begin
      v = lower;
      r.ovf = 1'b1;
    end
    neg = (v < 0);
    mag = neg ? -v : v;
    for (int d = NDIG - 1; d >= 0; d--) begin
      digit[d] = mag % 10;
      mag = mag / 10;
    end
    lit = 1'b0;
    for (int d = 0; d < NDIG; d++) begin
      if (digit[d] != 0) lit = 1'b1;
      // leading zeros blank, the last digit always shows
      pat = (lit || d == NDIG - 1) ? GLYPH[digit[d]] : sdsf_pkg::SEG_BLANK;
      if (pos != 0 && int'(pos) < NDIG && d == NDIG - 1 - int'(pos))
        pat = pat | sdsf_pkg::SEG_POINT;
      r.seg[d] = pat;
    end
    // minus overrides the whole leftmost pattern, point included
    if (neg) r.seg[0] = sdsf_pkg::SEG_MINUS;
    return r;
  endfunction

  task automatic note_mismatch(input string field, input int want, input int got);
    if (errors < 10)
      $display("%0t mismatch %s: expected %02h got %02h", $realtime, field, want, got);
    errors++;
  endtask

  initial begin
    errors = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    display_t want;
    display_t got;
    if (!rst) begin
      // check the finished transfer before taking a new one in the same cycle
      if (done) begin
        got.seg[0] = segments_digit_0;
        got.seg[1] = segments_digit_1;
        got.seg[2] = segments_digit_2;
        got.seg[3] = segments_digit_3;
        got.seg[4] = segments_digit_4;
        got.seg[5] = segments_digit_5;
        got.ovf = overflow;
        if (pending_displays.size() == 0) begin
          if (errors < 10) $display("%0t result with nothing pending", $realtime);
          errors++;
        end else begin
          want = pending_displays.pop_front();
          for (int d = 0; d < NDIG; d++)
            if (got.seg[d] !== want.seg[d])
              note_mismatch($sformatf("digit %0d", d), want.seg[d], got.seg[d]);
          if (got.ovf !== want.ovf) note_mismatch("overflow", want.ovf, got.ovf);
        end
      end
      if (start && !busy) pending_displays.push_back(format_display(value, point_position));
      outstanding = pending_displays.size();
    end
  end

endmodule

`default_nettype wire

// File: sim/tb_signed_decimal_seven_segment_formatter.sv
`default_nettype none

module tb_signed_decimal_seven_segment_formatter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1900;

  logic                                 clk;
  logic                                 rst;
  logic                                 start;
  logic                                 busy;
  logic                                 done;
  logic signed [sdsf_pkg::VALUE_W-1:0]  value;
  logic [sdsf_pkg::POS_W-1:0]           point_position;
  logic [sdsf_pkg::SEG_W-1:0]           segments_digit_0;
  logic [sdsf_pkg::SEG_W-1:0]           segments_digit_1;
  logic [sdsf_pkg::SEG_W-1:0]           segments_digit_2;
  logic [sdsf_pkg::SEG_W-1:0]           segments_digit_3;
  logic [sdsf_pkg::SEG_W-1:0]           segments_digit_4;
  logic [sdsf_pkg::SEG_W-1:0]           segments_digit_5;
  logic                                 overflow;
  int                                   errors;
  int                                   outstanding;

  signed_decimal_seven_segment_formatter dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .value            (value),
    .point_position   (point_position),
    .segments_digit_0 (segments_digit_0),
    .segments_digit_1 (segments_digit_1),
    .segments_digit_2 (segments_digit_2),
    .segments_digit_3 (segments_digit_3),
    .segments_digit_4 (segments_digit_4),
    .segments_digit_5 (segments_digit_5),
    .overflow         (overflow)
  );

  segment_pattern_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .value            (value),
    .point_position   (point_position),
    .segments_digit_0 (segments_digit_0),
    .segments_digit_1 (segments_digit_1),
    .segments_digit_2 (segments_digit_2),
    .segments_digit_3 (segments_digit_3),
    .segments_digit_4 (segments_digit_4),
    .segments_digit_5 (segments_digit_5),
    .overflow         (overflow),
    .errors           (errors),
    .outstanding      (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_display(input int num, input int pos);
    bit taken;
    value <= sdsf_pkg::VALUE_W'(num);
    point_position <= sdsf_pkg::POS_W'(pos);
    start <= 1'b1;
    do begin
      taken = !busy;
      @(negedge clk);
    end while (!taken);
  endtask

  // start held low while the inputs wiggle; n sets how long
  task automatic hold_off(input int n);
    if (n > 0) begin
      start <= 1'b0;
      for (int i = 0; i < n; i++) begin
        value <= sdsf_pkg::VALUE_W'($urandom);
        point_position <= sdsf_pkg::POS_W'($urandom);
        @(negedge clk);
      end
    end
  endtask

  initial begin
    int directed_val [20] = '{
      0, 0, 1, -1, 999999, 1000000, 1048575, -99999, -100000, -1048576,
      123456, 100000, 5, -5, -98765, 10, 999999, -1, 654321, 7
    };
    int directed_pos [20] = '{
      0, 2, 0, 5, 1, 0, 3, 5, 4, 0,
      6, 7, 3, 4, 5, 1, 5, 0, 2, 4
    };
    int edge_vals [16] = '{
      999999, 1000000, 999998, -99999, -100000, -99998, 1048575, -1048576,
      0, 99999, 100000, 9, 10, -9, -10, 1
    };
    int burst_left;
    int num;
    start = 1'b0;
    value = '0;
    point_position = '0;
    rst = 1'b1;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < 20; i++) send_display(directed_val[i], directed_pos[i]);

    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      case ($urandom_range(0, 9))
        0, 1: num = int'($urandom);
        2, 3: num = $urandom_range(0, 999999);
        4:    num = -int'($urandom_range(1, 99999));
        5:    num = int'($urandom_range(0, 2000)) - 1000;
        6:    num = edge_vals[$urandom_range(0, 15)];
        7: begin
          num = 10 ** $urandom_range(0, 6) + int'($urandom_range(0, 4)) - 2;
          if ($urandom_range(0, 1) == 1) num = -num;
        end
        default: num = $urandom_range(0, 99);
      endcase
      send_display(num, $urandom_range(0, 7));
    end
    start <= 1'b0;

    @(posedge clk);
    wait (outstanding == 0);
    repeat (30) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("PASS signed_decimal_seven_segment_formatter");
    end else begin
      $display("FAIL signed_decimal_seven_segment_formatter");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL signed_decimal_seven_segment_formatter");
    $finish;
  end

endmodule

`default_nettype wire
